@@ rtl/gpr_pkg.sv @@
// gpr_pkg: shared types and constants for the glyph pixel to RGBA converter.
// Holds the word structs, the mode codes and the stage struct of the divider pipe.
// No dependencies.
package gpr_pkg;

  localparam logic [7:0] CHAN_MAX     = 8'hFF;
  localparam logic [7:0] MONO_TOP_BIT = 8'h80;
  localparam int unsigned NUM_CHAN    = 3;
  localparam int unsigned DIV_STEPS   = 4;

  typedef enum logic [1:0] {
    MODE_GREY = 2'd0,
    MODE_MONO = 2'd1,
    MODE_BGRA = 2'd2,
    MODE_BAD  = 2'd3
  } gpr_mode_e;

  typedef struct packed {
    gpr_mode_e   mode;
    logic [31:0] src_word;
    logic [2:0]  bit_index;
  } gpr_in_t;

  typedef struct packed {
    logic [7:0] red_out;
    logic [7:0] green_out;
    logic [7:0] blue_out;
    logic [7:0] alpha_out;
    logic       is_bgra;
    logic       format_error;
  } gpr_out_t;

  // channel 0 blue, 1 green, 2 red
  typedef struct packed {
    logic [NUM_CHAN-1:0][15:0] rem;
    logic [14:0]               dvs;
    logic [NUM_CHAN-1:0][7:0]  quo;
    logic [NUM_CHAN-1:0]       sat;
    logic                      use_div;
    logic [7:0]                fix_rgb;
    logic [7:0]                alpha;
    logic                      is_bgra;
    logic                      format_error;
  } gpr_stage_t;

endpackage

@@ rtl/glyph_pixel_to_rgba.sv @@
// glyph_pixel_to_rgba: top level of the glyph pixel to straight-alpha RGBA8 converter.
// Depends on gpr_pkg, gpr_front, gpr_div_step and gpr_back.
//
// Use:
//   Input channel in_valid_i / in_stall_o / in_word_i carries one source pixel per word
//   (mode, src_word, bit_index). Output channel out_valid_o / out_stall_i / out_word_o
//   carries one RGBA word per input word, in order. A word moves on a rising edge with
//   valid high and stall low.
//   From acceptance to the result word being shown, a word passes through six
//   register stages: one decode stage, four divider stages that each settle two quotient
//   bits of the un-premultiply division, and the output register.
//   Throughput is one word per cycle; the pipeline takes a new word every cycle while
//   the receiver does not stall.
//   When the receiver stalls, the stall backs up stage by stage; empty stages still
//   fill, so words are accepted until the pipe is full. Nothing is lost or repeated.
//   Reset clears all stage valid bits; the block is ready straight after reset.
module glyph_pixel_to_rgba (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  gpr_pkg::gpr_in_t  in_word_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output gpr_pkg::gpr_out_t out_word_o
);

  logic [gpr_pkg::DIV_STEPS:0]                stg_valid;
  logic [gpr_pkg::DIV_STEPS:0]                stg_stall;
  gpr_pkg::gpr_stage_t [gpr_pkg::DIV_STEPS:0] stg_word;

  gpr_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_i),
    .stall_o (in_stall_o),
    .word_i  (in_word_i),
    .valid_o (stg_valid[0]),
    .stall_i (stg_stall[0]),
    .word_o  (stg_word[0])
  );

  for (genvar s = 0; s < gpr_pkg::DIV_STEPS; s++) begin : g_div
    gpr_div_step u_step (
      .clk_i   (clk_i),
      .rst_ni  (rst_ni),
      .valid_i (stg_valid[s]),
      .stall_o (stg_stall[s]),
      .word_i  (stg_word[s]),
      .valid_o (stg_valid[s+1]),
      .stall_i (stg_stall[s+1]),
      .word_o  (stg_word[s+1])
    );
  end

  gpr_back u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (stg_valid[gpr_pkg::DIV_STEPS]),
    .stall_o (stg_stall[gpr_pkg::DIV_STEPS]),
    .word_i  (stg_word[gpr_pkg::DIV_STEPS]),
    .valid_o (out_valid_o),
    .stall_i (out_stall_i),
    .word_o  (out_word_o)
  );

endmodule

@@ rtl/gpr_front.sv @@
// gpr_front: first pipeline stage; decodes the mode and forms the numerators.
// Depends on gpr_pkg.
module gpr_front (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  gpr_pkg::gpr_in_t    word_i,
  output logic                valid_o,
  input  logic                stall_i,
  output gpr_pkg::gpr_stage_t word_o
);

  logic                valid_q;
  gpr_pkg::gpr_stage_t word_q, word_d;
  logic                load;

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    logic [7:0]  a;
    logic [7:0]  c;
    logic [15:0] n;
    a = word_i.src_word[31:24];
    word_d = '0;
    word_d.dvs = {a, 7'b0};
    for (int i = 0; i < gpr_pkg::NUM_CHAN; i++) begin
      c = word_i.src_word[8*i +: 8];
      n = ({c, 8'h00} - {8'h00, c}) + {9'b0, a[7:1]};
      word_d.rem[i] = n;
      word_d.sat[i] = (n >= {a, 8'h00});
    end
    case (word_i.mode)
      gpr_pkg::MODE_GREY: begin
        word_d.fix_rgb = gpr_pkg::CHAN_MAX;
        word_d.alpha   = word_i.src_word[7:0];
      end
      gpr_pkg::MODE_MONO: begin
        word_d.fix_rgb = gpr_pkg::CHAN_MAX;
        word_d.alpha   = ((word_i.src_word[7:0] & (gpr_pkg::MONO_TOP_BIT >> word_i.bit_index))
                          != 8'h00) ? gpr_pkg::CHAN_MAX : 8'h00;
      end
      gpr_pkg::MODE_BGRA: begin
        // zero alpha takes the fixed path with black
        word_d.use_div = (a != 8'h00);
        word_d.alpha   = a;
        word_d.is_bgra = 1'b1;
      end
      default: begin
        word_d.format_error = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

endmodule

@@ rtl/gpr_div_step.sv @@
// gpr_div_step: one divider stage; two restoring quotient bits per colour channel.
// Depends on gpr_pkg.
module gpr_div_step (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  gpr_pkg::gpr_stage_t word_i,
  output logic                valid_o,
  input  logic                stall_i,
  output gpr_pkg::gpr_stage_t word_o
);

  logic                valid_q;
  gpr_pkg::gpr_stage_t word_q, word_d;
  logic                load;

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    logic [14:0] d0;
    logic [14:0] d1;
    logic [15:0] r;
    logic [7:0]  q;
    d0 = word_i.dvs;
    d1 = word_i.dvs >> 1;
    word_d = word_i;
    word_d.dvs = word_i.dvs >> 2;
    for (int i = 0; i < gpr_pkg::NUM_CHAN; i++) begin
      r = word_i.rem[i];
      q = word_i.quo[i];
      if (r >= {1'b0, d0}) begin
        r = r - {1'b0, d0};
        q = {q[6:0], 1'b1};
      end else begin
        q = {q[6:0], 1'b0};
      end
      if (r >= {1'b0, d1}) begin
        r = r - {1'b0, d1};
        q = {q[6:0], 1'b1};
      end else begin
        q = {q[6:0], 1'b0};
      end
      word_d.rem[i] = r;
      word_d.quo[i] = q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

endmodule

@@ rtl/gpr_back.sv @@
// gpr_back: output stage; applies saturation and selects the result word.
// Depends on gpr_pkg.
module gpr_back (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                valid_i,
  output logic                stall_o,
  input  gpr_pkg::gpr_stage_t word_i,
  output logic                valid_o,
  input  logic                stall_i,
  output gpr_pkg::gpr_out_t   word_o
);

  logic              valid_q;
  gpr_pkg::gpr_out_t word_q, word_d;
  logic              load;
  logic [gpr_pkg::NUM_CHAN-1:0][7:0] chan;

  assign load    = !valid_q || !stall_i;
  assign stall_o = !load;
  assign valid_o = valid_q;
  assign word_o  = word_q;

  always_comb begin
    for (int i = 0; i < gpr_pkg::NUM_CHAN; i++) begin
      if (!word_i.use_div) begin
        chan[i] = word_i.fix_rgb;
      end else if (word_i.sat[i]) begin
        chan[i] = gpr_pkg::CHAN_MAX;
      end else begin
        chan[i] = word_i.quo[i];
      end
    end
    word_d.blue_out     = chan[0];
    word_d.green_out    = chan[1];
    word_d.red_out      = chan[2];
    word_d.alpha_out    = word_i.alpha;
    word_d.is_bgra      = word_i.is_bgra;
    word_d.format_error = word_i.format_error;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (load) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      word_q <= word_d;
    end
  end

endmodule
